FILE: sv/wfd_pkg.sv
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam int LEN_W = 63;
    localparam int ACC_W = 64;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 63'd65535;

    // parse phase codes
    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // length codes of the second header byte
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       payload_byte;
        logic [3:0]       opcode;
        logic             fin_bit;
        logic [2:0]       reserved_bits;
        logic [LEN_W-1:0] payload_length;
        logic             last_of_frame;
    } res_t;

endpackage

FILE: sv/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// WebSocket receive-side frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat, a byte every cycle while s_ready is high.
// Header bytes give no result until the header is complete, then one header
// result (or an oversize error) comes out; each payload byte gives one
// unmasked result, the final one flagged last. A two-deep output stage (result
// register plus skid) lets input run while a result waits; s_ready drops only
// when both are full. Payload of an oversize frame is consumed at one byte per
// cycle while s_ready is high, with no results. The user must set the length
// limit (cfg_wr_en / cfg_wr_data) only while idle; it is not enforced.
module websocket_frame_deframer_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [7:0]                m_payload_byte,
    output logic [3:0]                m_opcode,
    output logic                      m_fin_bit,
    output logic [2:0]                m_reserved_bits,
    output logic [wfd_pkg::LEN_W-1:0] m_payload_length,
    output logic                      m_last_of_frame,
    input  logic                      cfg_wr_en,
    input  logic [wfd_pkg::LEN_W-1:0] cfg_wr_data
);
    import wfd_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             accept;
    logic             res_valid;
    res_t             res;
    res_t             out_data;

    assign accept = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    wfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_kind           = out_data.kind;
    assign m_payload_byte   = out_data.payload_byte;
    assign m_opcode         = out_data.opcode;
    assign m_fin_bit        = out_data.fin_bit;
    assign m_reserved_bits  = out_data.reserved_bits;
    assign m_payload_length = out_data.payload_length;
    assign m_last_of_frame  = out_data.last_of_frame;

endmodule

FILE: sv/wfd_parser.sv
// ----------------------------------------------------------------------------
// wfd_parser
// Frame header parser and payload unmasker, one byte per accepted beat.
// ----------------------------------------------------------------------------
module wfd_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic [wfd_pkg::LEN_W-1:0] max_len,
    output logic                     res_valid,
    output wfd_pkg::res_t            res
);
    import wfd_pkg::*;

    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             fin_reg, fin_next;
    logic [2:0]       rsv_reg, rsv_next;
    logic             masked_reg, masked_next;
    logic [ACC_W-1:0] len_reg, len_next;
    logic [31:0]      key_reg, key_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             drop_reg, drop_next;

    logic             do_after;
    logic             do_finish;
    logic             produce;
    logic [3:0]       cnt_inc;
    logic [3:0]       need;
    logic [ACC_W-1:0] len_dec;
    logic [ACC_W-1:0] idx_inc;
    logic             last;
    logic [7:0]       key_byte;

    assign cnt_inc = cnt_reg + 4'd1;
    assign need    = (phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
    assign len_dec = (len_reg != '0) ? len_reg - ACC_W'(1) : len_reg;
    assign idx_inc = {1'b0, idx_reg} + ACC_W'(1);
    assign last    = (idx_inc >= len_reg);

    always_comb begin
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        drop_next   = drop_reg;
        do_after    = 1'b0;
        do_finish   = 1'b0;
        produce     = 1'b0;

        res.kind           = KIND_HEADER;
        res.payload_byte   = 8'd0;
        res.opcode         = opcode_reg;
        res.fin_bit        = fin_reg;
        res.reserved_bits  = rsv_reg;
        res.payload_length = len_reg[LEN_W-1:0];
        res.last_of_frame  = 1'b0;

        case (phase_reg)
            PH_BYTE0: begin
                fin_next    = data_byte[7];
                rsv_next    = data_byte[6:4];
                opcode_next = data_byte[3:0];
                cnt_next    = 4'd0;
                phase_next  = PH_BYTE1;
            end
            PH_BYTE1: begin
                masked_next = data_byte[7];
                cnt_next    = 4'd0;
                if (data_byte[6:0] == LEN_CODE_EXT16) begin
                    len_next   = '0;
                    phase_next = PH_EXT16;
                end else if (data_byte[6:0] == LEN_CODE_EXT64) begin
                    len_next   = '0;
                    phase_next = PH_EXT64;
                end else begin
                    len_next = {{(ACC_W-7){1'b0}}, data_byte[6:0]};
                    do_after = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                len_next = {len_reg[ACC_W-9:0], data_byte};
                cnt_next = cnt_inc;
                if (cnt_inc >= need) begin
                    do_after = 1'b1;
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], data_byte};
                cnt_next = cnt_inc;
                if (cnt_inc >= KEY_BYTES) begin
                    do_finish = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (drop_reg) begin
                    len_next = len_dec;
                    if (len_dec == '0) begin
                        drop_next  = 1'b0;
                        phase_next = PH_BYTE0;
                    end
                end else begin
                    produce            = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.payload_byte   = masked_reg ? (data_byte ^ key_byte) : data_byte;
                    res.last_of_frame  = last;
                    if (last) begin
                        idx_next   = '0;
                        phase_next = PH_BYTE0;
                    end else begin
                        idx_next = idx_inc[LEN_W-1:0];
                    end
                end
            end
            default: begin
                phase_next = PH_BYTE0;
                cnt_next   = 4'd0;
            end
        endcase

        // length known: either collect the key or close the header
        if (do_after) begin
            cnt_next = 4'd0;
            if (masked_next) begin
                phase_next = PH_MASK;
                key_next   = '0;
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            cnt_next = 4'd0;
            idx_next = '0;
            produce  = 1'b1;
            if (len_next > {1'b0, max_len}) begin
                res.kind           = KIND_ERROR;
                res.payload_length = len_next[ACC_W-1] ? {LEN_W{1'b1}} : len_next[LEN_W-1:0];
                res.last_of_frame  = 1'b1;
                drop_next          = 1'b1;
                phase_next         = PH_PAYLOAD;
            end else begin
                res.kind           = KIND_HEADER;
                res.payload_length = len_next[LEN_W-1:0];
                res.last_of_frame  = (len_next == '0);
                drop_next          = 1'b0;
                phase_next         = (len_next != '0) ? PH_PAYLOAD : PH_BYTE0;
            end
        end
    end

    assign res_valid = accept & produce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_BYTE0;
            cnt_reg    <= 4'd0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            rsv_reg    <= 3'd0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

FILE: sv/wfd_out_buf.sv
// ----------------------------------------------------------------------------
// wfd_out_buf
// Result register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module wfd_out_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  wfd_pkg::res_t in_data,
    output logic          in_ready,
    output logic          out_valid,
    output wfd_pkg::res_t out_data,
    input  logic          out_ready
);
    import wfd_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up this cycle
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: test/websocket_frame_deframer_unit_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_check
// Watches both channels of the deframer. It keeps its own copy of the
// parser and the length limit, and from each byte taken it works out the
// header, error and unmasked payload results. Each result that leaves the
// block is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_check (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [1:0]                m_kind,
    input  logic [7:0]                m_payload_byte,
    input  logic [3:0]                m_opcode,
    input  logic                      m_fin_bit,
    input  logic [2:0]                m_reserved_bits,
    input  logic [wfd_pkg::LEN_W-1:0] m_payload_length,
    input  logic                      m_last_of_frame,
    input  logic                      cfg_wr_en,
    input  logic [wfd_pkg::LEN_W-1:0] cfg_wr_data,
    output int                        fail_count,
    output int                        results_due
);
    import wfd_pkg::*;

    logic [LEN_W-1:0] len_limit;
    logic [2:0]       phase;
    logic [3:0]       hdr_cnt;
    logic [3:0]       frm_opcode;
    logic             frm_fin;
    logic [2:0]       frm_rsv;
    logic             frm_masked;
    logic [ACC_W-1:0] len_acc;
    logic [31:0]      mask_key;
    logic [LEN_W-1:0] pay_idx;
    logic             dropping;

    res_t frame_results_due[$];
    int   mismatches = 0;

    task automatic post_result(input logic [1:0] k, input logic [7:0] pb,
                               input logic [LEN_W-1:0] len, input logic last);
        res_t r;
        r.kind           = k;
        r.payload_byte   = pb;
        r.opcode         = frm_opcode;
        r.fin_bit        = frm_fin;
        r.reserved_bits  = frm_rsv;
        r.payload_length = len;
        r.last_of_frame  = last;
        frame_results_due.push_back(r);
    endtask

    task automatic close_header();
        hdr_cnt = '0;
        pay_idx = '0;
        if (len_acc > {1'b0, len_limit}) begin
            // oversize: saturate a length that does not fit 63 bits
            post_result(KIND_ERROR, 8'h00,
                        len_acc[ACC_W-1] ? {LEN_W{1'b1}} : len_acc[LEN_W-1:0], 1'b1);
            dropping = 1'b1;
            phase    = PH_PAYLOAD;
        end else begin
            dropping = 1'b0;
            post_result(KIND_HEADER, 8'h00, len_acc[LEN_W-1:0], len_acc == '0);
            phase = (len_acc != '0) ? PH_PAYLOAD : PH_BYTE0;
        end
    endtask

    task automatic end_of_length();
        hdr_cnt = '0;
        if (frm_masked) begin
            phase    = PH_MASK;
            mask_key = '0;
        end else begin
            close_header();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0]       v;
        logic             last;
        logic [3:0]       need;
        case (phase)
            PH_BYTE0: begin
                frm_fin    = b[7];
                frm_rsv    = b[6:4];
                frm_opcode = b[3:0];
                hdr_cnt    = '0;
                phase      = PH_BYTE1;
            end
            PH_BYTE1: begin
                frm_masked = b[7];
                len_acc    = '0;
                hdr_cnt    = '0;
                if (b[6:0] == LEN_CODE_EXT16) begin
                    phase = PH_EXT16;
                end else if (b[6:0] == LEN_CODE_EXT64) begin
                    phase = PH_EXT64;
                end else begin
                    len_acc = {57'd0, b[6:0]};
                    end_of_length();
                end
            end
            PH_EXT16, PH_EXT64: begin
                need    = (phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                len_acc = {len_acc[ACC_W-9:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= need) end_of_length();
            end
            PH_MASK: begin
                mask_key = {mask_key[23:0], b};
                hdr_cnt  = hdr_cnt + 4'd1;
                if (hdr_cnt >= KEY_BYTES) close_header();
            end
            PH_PAYLOAD: begin
                if (dropping) begin
                    if (len_acc != '0) len_acc = len_acc - 64'd1;
                    if (len_acc == '0) begin
                        dropping = 1'b0;
                        phase    = PH_BYTE0;
                    end
                end else begin
                    v = b;
                    // first key byte received goes with index 0
                    if (frm_masked) v = v ^ mask_key[(3 - pay_idx[1:0]) * 8 +: 8];
                    last = ({1'b0, pay_idx} + 64'd1 >= len_acc);
                    post_result(KIND_PAYLOAD, v, len_acc[LEN_W-1:0], last);
                    pay_idx = pay_idx + 1'b1;
                    if (last) begin
                        pay_idx = '0;
                        phase   = PH_BYTE0;
                    end
                end
            end
            default: begin
                phase   = PH_BYTE0;
                hdr_cnt = '0;
            end
        endcase
    endtask

    task automatic check_result();
        res_t want;
        if (frame_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result kind %0d byte %02h len %0d last %0b",
                         $realtime, m_kind, m_payload_byte, m_payload_length,
                         m_last_of_frame);
            return;
        end
        want = frame_results_due.pop_front();
        if (m_kind !== want.kind || m_payload_byte !== want.payload_byte ||
            m_opcode !== want.opcode || m_fin_bit !== want.fin_bit ||
            m_reserved_bits !== want.reserved_bits ||
            m_payload_length !== want.payload_length ||
            m_last_of_frame !== want.last_of_frame) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch exp/got kind %0d/%0d byte %02h/%02h op %0h/%0h",
                          " fin %0b/%0b rsv %0d/%0d len %0d/%0d last %0b/%0b"},
                         $realtime, want.kind, m_kind, want.payload_byte, m_payload_byte,
                         want.opcode, m_opcode, want.fin_bit, m_fin_bit,
                         want.reserved_bits, m_reserved_bits,
                         want.payload_length, m_payload_length,
                         want.last_of_frame, m_last_of_frame);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            len_limit  = MAX_LEN_RESET;
            phase      = PH_BYTE0;
            hdr_cnt    = '0;
            frm_opcode = '0;
            frm_fin    = 1'b0;
            frm_rsv    = '0;
            frm_masked = 1'b0;
            len_acc    = '0;
            mask_key   = '0;
            pay_idx    = '0;
            dropping   = 1'b0;
            frame_results_due.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_wr_en) len_limit = cfg_wr_data;
            if (s_valid && s_ready) deframe_byte(s_data_byte);
        end
        results_due <= frame_results_due.size();
        fail_count  <= mismatches;
    end

endmodule

FILE: test/websocket_frame_deframer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_test
// Regression for the deframer: directed frames (empty, masked, extended
// length forms, limit edges, oversize drops, saturated length) followed by
// random well-formed frame streams under several length limits, with bursty
// input and a stalling receiver. The checker module does the prediction.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_test;
    import wfd_pkg::*;

    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    localparam int RX_STEADY = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = 8'h00;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_kind;
    logic [7:0]       m_payload_byte;
    logic [3:0]       m_opcode;
    logic             m_fin_bit;
    logic [2:0]       m_reserved_bits;
    logic [LEN_W-1:0] m_payload_length;
    logic             m_last_of_frame;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int results_due;

    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    int          ready_mode = RX_STEADY;
    int unsigned ready_run  = 0;

    websocket_frame_deframer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_opcode         (m_opcode),
        .m_fin_bit        (m_fin_bit),
        .m_reserved_bits  (m_reserved_bits),
        .m_payload_length (m_payload_length),
        .m_last_of_frame  (m_last_of_frame),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    websocket_frame_deframer_unit_check checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_payload_byte   (m_payload_byte),
        .m_opcode         (m_opcode),
        .m_fin_bit        (m_fin_bit),
        .m_reserved_bits  (m_reserved_bits),
        .m_payload_length (m_payload_length),
        .m_last_of_frame  (m_last_of_frame),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .fail_count       (fail_count),
        .results_due      (results_due)
    );

    always #5 aclk = ~aclk;

    // receiver stalls in runs of random length and density
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = int'($urandom_range(RX_STEADY, RX_SPARSE));
            ready_run  = $urandom_range(1, 40);
        end
        ready_run--;
        case (ready_mode)
            RX_STEADY: m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // body is the number of payload beats actually sent
    task automatic send_frame(input logic [7:0] head, input logic masked, input int form,
                              input logic [63:0] len, input logic [31:0] key,
                              input int unsigned body);
        send_byte(head);
        case (form)
            FORM_SHORT: send_byte({masked, len[6:0]});
            FORM_EXT16: begin
                send_byte({masked, LEN_CODE_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({masked, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--) send_byte(key[i*8 +: 8]);
        repeat (body) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_traffic(input int unsigned byte_goal);
        int unsigned start;
        int unsigned pick;
        logic [63:0] len;
        int          form;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      len = 64'($urandom_range(0, 12));
            else if (pick < 95) len = 64'($urandom_range(13, 130));
            else                len = 64'($urandom_range(131, 300));
            form = (len <= 125) ? int'($urandom_range(FORM_SHORT, FORM_EXT64))
                                : int'($urandom_range(FORM_EXT16, FORM_EXT64));
            send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len,
                       $urandom(), len[31:0]);
        end
    endtask

    task automatic drain_then_limit(input logic [LEN_W-1:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [63:0] huge_len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit still in force
        send_frame(8'h00, 1'b0, FORM_SHORT, 0, 32'h0, 0);
        send_frame(8'hFF, 1'b1, FORM_SHORT, 0, 32'hA1B2C3D4, 0);
        send_frame(8'h81, 1'b1, FORM_SHORT, 5, 32'hFF00FF00, 5);
        send_frame(8'h7A, 1'b1, FORM_EXT16, 3, $urandom(), 3);
        send_frame(8'h42, 1'b0, FORM_EXT64, 2, 32'h0, 2);
        send_frame(8'hC9, 1'b0, FORM_EXT16, 0, 32'h0, 0);

        // zero limit: only empty frames pass
        drain_then_limit('0);
        send_frame(8'h01, 1'b0, FORM_SHORT, 0, 32'h0, 0);
        send_frame(8'h82, 1'b0, FORM_SHORT, 1, 32'h0, 1);
        send_frame(8'h3C, 1'b1, FORM_SHORT, 3, $urandom(), 3);
        send_frame(8'h88, 1'b0, FORM_EXT64, 2, 32'h0, 2);

        // exactly at the limit, then one past it
        drain_then_limit(63'd40);
        send_frame(8'h82, 1'b1, FORM_EXT16, 40, $urandom(), 40);
        send_frame(8'h02, 1'b0, FORM_SHORT, 41, 32'h0, 41);
        random_traffic(80);

        drain_then_limit(LEN_W'($urandom_range(0, 60)));
        random_traffic(80);

        drain_then_limit(MAX_LEN_RESET);
        random_traffic(80);

        drain_then_limit({LEN_W{1'b1}});
        random_traffic(80);

        // top length bit set: always oversize, stream stays in drop mode after
        huge_len     = {$urandom(), $urandom()};
        huge_len[63] = 1'b1;
        send_frame(8'($urandom_range(0, 255)), 1'b1, FORM_EXT64, huge_len, $urandom(), 5);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
